// File: hdl/msgpack_value_encoder_top_macros.svh
// Assertion macros for the MessagePack value encoder.
// Expects clk and rst_n in the scope of use.
`ifndef MSGPACK_VALUE_ENCODER_TOP_MACROS_SVH
`define MSGPACK_VALUE_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MPENC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MPENC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mpenc_pkg.sv
// Shared types and byte codes of the MessagePack value encoder.
// No dependencies.
`default_nettype none

package mpenc_pkg;

  localparam int unsigned FRAME_BYTES = 15;
  localparam int unsigned FRAME_BITS  = FRAME_BYTES * 8;
  localparam int unsigned CNT_W       = $clog2(FRAME_BYTES + 1);

  typedef enum logic [3:0] {
    ACT_NIL     = 4'd0,
    ACT_BOOL    = 4'd1,
    ACT_UINT    = 4'd2,
    ACT_INT     = 4'd3,
    ACT_FLOAT   = 4'd4,
    ACT_STR     = 4'd5,
    ACT_BIN     = 4'd6,
    ACT_ARRAY   = 4'd7,
    ACT_MAP     = 4'd8,
    ACT_EXT     = 4'd9,
    ACT_TSTAMP  = 4'd10,
    ACT_PAYLOAD = 4'd11
  } action_t;

  localparam logic [7:0] MP_NIL      = 8'hC0;
  localparam logic [7:0] MP_FALSE    = 8'hC2;
  localparam logic [7:0] MP_TRUE     = 8'hC3;
  localparam logic [7:0] MP_BIN8     = 8'hC4;
  localparam logic [7:0] MP_BIN16    = 8'hC5;
  localparam logic [7:0] MP_BIN32    = 8'hC6;
  localparam logic [7:0] MP_EXT8     = 8'hC7;
  localparam logic [7:0] MP_EXT16    = 8'hC8;
  localparam logic [7:0] MP_EXT32    = 8'hC9;
  localparam logic [7:0] MP_FLOAT32  = 8'hCA;
  localparam logic [7:0] MP_FLOAT64  = 8'hCB;
  localparam logic [7:0] MP_UINT8    = 8'hCC;
  localparam logic [7:0] MP_UINT16   = 8'hCD;
  localparam logic [7:0] MP_UINT32   = 8'hCE;
  localparam logic [7:0] MP_UINT64   = 8'hCF;
  localparam logic [7:0] MP_INT8     = 8'hD0;
  localparam logic [7:0] MP_INT16    = 8'hD1;
  localparam logic [7:0] MP_INT32    = 8'hD2;
  localparam logic [7:0] MP_INT64    = 8'hD3;
  localparam logic [7:0] MP_FIXEXT1  = 8'hD4;
  localparam logic [7:0] MP_FIXEXT2  = 8'hD5;
  localparam logic [7:0] MP_FIXEXT4  = 8'hD6;
  localparam logic [7:0] MP_FIXEXT8  = 8'hD7;
  localparam logic [7:0] MP_FIXEXT16 = 8'hD8;
  localparam logic [7:0] MP_STR8     = 8'hD9;
  localparam logic [7:0] MP_STR16    = 8'hDA;
  localparam logic [7:0] MP_STR32    = 8'hDB;
  localparam logic [7:0] MP_ARRAY16  = 8'hDC;
  localparam logic [7:0] MP_ARRAY32  = 8'hDD;
  localparam logic [7:0] MP_MAP16    = 8'hDE;
  localparam logic [7:0] MP_MAP32    = 8'hDF;
  localparam logic [7:0] MP_FIXSTR   = 8'hA0;
  localparam logic [7:0] MP_FIXARRAY = 8'h90;
  localparam logic [7:0] MP_FIXMAP   = 8'h80;
  localparam logic [7:0] MP_TS_TYPE  = 8'hFF;
  localparam logic [7:0] MP_TS96_LEN = 8'd12;

  // Registered input word
  typedef struct packed {
    logic [3:0]         action;
    logic [63:0]        unsigned_value;
    logic signed [63:0] signed_value;
    logic [31:0]        length;
    logic signed [7:0]  ext_type;
    logic [29:0]        nanoseconds;
    logic               flag;
    logic [7:0]         payload_byte;
  } item_t;

  // Encoded bytes, first byte in the top bits, plus byte count
  typedef struct packed {
    logic [FRAME_BITS-1:0] data;
    logic [CNT_W-1:0]      count;
  } frame_t;

  // Output shifter status toward the input stage
  typedef struct packed {
    logic valid;
    logic last;
  } sh_status_t;

endpackage

`default_nettype wire

// File: hdl/mpenc_encode.sv
// Combinational MessagePack encoding of one registered input word.
// Depends on mpenc_pkg.
`default_nettype none

module mpenc_encode (
  input  wire mpenc_pkg::item_t  item,
  output mpenc_pkg::frame_t      frame
);

  function automatic mpenc_pkg::frame_t enc_uint(input logic [63:0] u);
    mpenc_pkg::frame_t f;
    if (u[63:7] == '0) begin
      f.data = {u[7:0], 112'b0};                  f.count = 4'd1;
    end else if (u[63:8] == '0) begin
      f.data = {mpenc_pkg::MP_UINT8, u[7:0], 104'b0};   f.count = 4'd2;
    end else if (u[63:16] == '0) begin
      f.data = {mpenc_pkg::MP_UINT16, u[15:0], 96'b0};  f.count = 4'd3;
    end else if (u[63:32] == '0) begin
      f.data = {mpenc_pkg::MP_UINT32, u[31:0], 80'b0};  f.count = 4'd5;
    end else begin
      f.data = {mpenc_pkg::MP_UINT64, u, 48'b0};        f.count = 4'd9;
    end
    return f;
  endfunction

  function automatic mpenc_pkg::frame_t enc_int(input logic [63:0] v);
    mpenc_pkg::frame_t f;
    if (!v[63]) begin
      f = enc_uint(v);
    end else if (&v[63:5]) begin
      f.data = {v[7:0], 112'b0};                       f.count = 4'd1;
    end else if (&v[63:7]) begin
      f.data = {mpenc_pkg::MP_INT8, v[7:0], 104'b0};   f.count = 4'd2;
    end else if (&v[63:15]) begin
      f.data = {mpenc_pkg::MP_INT16, v[15:0], 96'b0};  f.count = 4'd3;
    end else if (&v[63:31]) begin
      f.data = {mpenc_pkg::MP_INT32, v[31:0], 80'b0};  f.count = 4'd5;
    end else begin
      f.data = {mpenc_pkg::MP_INT64, v, 48'b0};        f.count = 4'd9;
    end
    return f;
  endfunction

  // float32 only when the double narrows without loss
  function automatic mpenc_pkg::frame_t enc_float(input logic [63:0] d);
    mpenc_pkg::frame_t f;
    logic [10:0] ef;
    logic [51:0] frac;
    logic [52:0] m;
    logic [52:0] q;
    logic [5:0]  s;
    logic [10:0] e8;
    logic        exact;
    logic [31:0] f32;
    ef    = d[62:52];
    frac  = d[51:0];
    m     = {1'b1, frac};
    s     = 6'((11'd926 - ef));
    q     = m >> s;
    e8    = ef - 11'd896;
    exact = 1'b0;
    f32   = {d[63], 31'b0};
    if (ef == 11'h7FF) begin
      exact = (frac == '0);
      f32   = {d[63], 8'hFF, 23'b0};
    end else if (ef == '0) begin
      exact = (frac == '0);
    end else if (ef >= 11'd897 && ef <= 11'd1150) begin
      exact = (frac[28:0] == '0);
      f32   = {d[63], e8[7:0], frac[51:29]};
    end else if (ef >= 11'd874 && ef <= 11'd896) begin
      // lands on a float32 subnormal
      exact = ((q << s) == m);
      f32   = {d[63], 8'b0, q[22:0]};
    end
    if (exact) begin
      f.data = {mpenc_pkg::MP_FLOAT32, f32, 80'b0};  f.count = 4'd5;
    end else begin
      f.data = {mpenc_pkg::MP_FLOAT64, d, 48'b0};    f.count = 4'd9;
    end
    return f;
  endfunction

  function automatic mpenc_pkg::frame_t enc_len(input logic [31:0] len,
                                                input logic [7:0] c8,
                                                input logic [7:0] c16,
                                                input logic [7:0] c32);
    mpenc_pkg::frame_t f;
    if (len[31:8] == '0) begin
      f.data = {c8, len[7:0], 104'b0};   f.count = 4'd2;
    end else if (len[31:16] == '0) begin
      f.data = {c16, len[15:0], 96'b0};  f.count = 4'd3;
    end else begin
      f.data = {c32, len, 80'b0};        f.count = 4'd5;
    end
    return f;
  endfunction

  function automatic mpenc_pkg::frame_t enc_coll(input logic [31:0] len,
                                                 input logic [7:0] fix,
                                                 input logic [7:0] c16,
                                                 input logic [7:0] c32);
    mpenc_pkg::frame_t f;
    if (len[31:4] == '0) begin
      f.data = {fix | {4'b0, len[3:0]}, 112'b0};  f.count = 4'd1;
    end else if (len[31:16] == '0) begin
      f.data = {c16, len[15:0], 96'b0};           f.count = 4'd3;
    end else begin
      f.data = {c32, len, 80'b0};                 f.count = 4'd5;
    end
    return f;
  endfunction

  function automatic mpenc_pkg::frame_t enc_ext(input logic [31:0] len,
                                                input logic [7:0] et);
    mpenc_pkg::frame_t f;
    case (len)
      32'd1:   begin f.data = {mpenc_pkg::MP_FIXEXT1, et, 104'b0};  f.count = 4'd2; end
      32'd2:   begin f.data = {mpenc_pkg::MP_FIXEXT2, et, 104'b0};  f.count = 4'd2; end
      32'd4:   begin f.data = {mpenc_pkg::MP_FIXEXT4, et, 104'b0};  f.count = 4'd2; end
      32'd8:   begin f.data = {mpenc_pkg::MP_FIXEXT8, et, 104'b0};  f.count = 4'd2; end
      32'd16:  begin f.data = {mpenc_pkg::MP_FIXEXT16, et, 104'b0}; f.count = 4'd2; end
      default: begin
        if (len[31:8] == '0) begin
          f.data = {mpenc_pkg::MP_EXT8, len[7:0], et, 96'b0};   f.count = 4'd3;
        end else if (len[31:16] == '0) begin
          f.data = {mpenc_pkg::MP_EXT16, len[15:0], et, 88'b0}; f.count = 4'd4;
        end else begin
          f.data = {mpenc_pkg::MP_EXT32, len, et, 72'b0};       f.count = 4'd6;
        end
      end
    endcase
    return f;
  endfunction

  function automatic mpenc_pkg::frame_t enc_tstamp(input logic [63:0] sec,
                                                   input logic [29:0] ns);
    mpenc_pkg::frame_t f;
    if (sec[63:34] == '0) begin
      if (ns == '0 && sec[33:32] == '0) begin
        f.data  = {mpenc_pkg::MP_FIXEXT4, mpenc_pkg::MP_TS_TYPE, sec[31:0], 72'b0};
        f.count = 4'd6;
      end else begin
        f.data  = {mpenc_pkg::MP_FIXEXT8, mpenc_pkg::MP_TS_TYPE, ns, sec[33:0], 40'b0};
        f.count = 4'd10;
      end
    end else begin
      f.data  = {mpenc_pkg::MP_EXT8, mpenc_pkg::MP_TS96_LEN, mpenc_pkg::MP_TS_TYPE,
                 2'b0, ns, sec};
      f.count = 4'd15;
    end
    return f;
  endfunction

  always_comb begin
    frame.data  = '0;
    frame.count = '0;
    case (item.action)
      mpenc_pkg::ACT_NIL: begin
        frame.data  = {mpenc_pkg::MP_NIL, 112'b0};
        frame.count = 4'd1;
      end
      mpenc_pkg::ACT_BOOL: begin
        frame.data  = {(item.flag ? mpenc_pkg::MP_TRUE : mpenc_pkg::MP_FALSE), 112'b0};
        frame.count = 4'd1;
      end
      mpenc_pkg::ACT_UINT:  frame = enc_uint(item.unsigned_value);
      mpenc_pkg::ACT_INT:   frame = enc_int(item.signed_value);
      mpenc_pkg::ACT_FLOAT: frame = enc_float(item.unsigned_value);
      mpenc_pkg::ACT_STR: begin
        if (item.length[31:5] == '0) begin
          frame.data  = {mpenc_pkg::MP_FIXSTR | {3'b0, item.length[4:0]}, 112'b0};
          frame.count = 4'd1;
        end else begin
          frame = enc_len(item.length, mpenc_pkg::MP_STR8, mpenc_pkg::MP_STR16,
                          mpenc_pkg::MP_STR32);
        end
      end
      mpenc_pkg::ACT_BIN:
        frame = enc_len(item.length, mpenc_pkg::MP_BIN8, mpenc_pkg::MP_BIN16,
                        mpenc_pkg::MP_BIN32);
      mpenc_pkg::ACT_ARRAY:
        frame = enc_coll(item.length, mpenc_pkg::MP_FIXARRAY, mpenc_pkg::MP_ARRAY16,
                         mpenc_pkg::MP_ARRAY32);
      mpenc_pkg::ACT_MAP:
        frame = enc_coll(item.length, mpenc_pkg::MP_FIXMAP, mpenc_pkg::MP_MAP16,
                         mpenc_pkg::MP_MAP32);
      mpenc_pkg::ACT_EXT:    frame = enc_ext(item.length, item.ext_type);
      mpenc_pkg::ACT_TSTAMP: frame = enc_tstamp(item.signed_value, item.nanoseconds);
      mpenc_pkg::ACT_PAYLOAD: begin
        frame.data  = {item.payload_byte, 112'b0};
        frame.count = 4'd1;
      end
      default: begin
        // unused action codes emit nothing
        frame.data  = '0;
        frame.count = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/mpenc_shifter.sv
// Output byte shifter: holds one encoded frame and sends a byte per cycle.
// Depends on mpenc_pkg.
`default_nettype none

module mpenc_shifter (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          load,
  input  wire mpenc_pkg::frame_t       frame,
  output mpenc_pkg::sh_status_t        status,
  output logic [7:0]                   out_byte
);

  logic [mpenc_pkg::FRAME_BITS-1:0] data_r, data_nxt;
  logic [mpenc_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                             vld_r, vld_nxt;

  always_comb begin
    data_nxt = data_r;
    cnt_nxt  = cnt_r;
    vld_nxt  = vld_r;
    if (load) begin
      data_nxt = frame.data;
      cnt_nxt  = frame.count;
      vld_nxt  = (frame.count != '0);
    end else if (vld_r) begin
      data_nxt = {data_r[mpenc_pkg::FRAME_BITS-9:0], 8'b0};
      cnt_nxt  = cnt_r - 1'b1;
      vld_nxt  = (cnt_r != 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign status.valid = vld_r;
  assign status.last  = vld_r && (cnt_r == 1);
  assign out_byte     = data_r[mpenc_pkg::FRAME_BITS-1 -: 8];

endmodule

`default_nettype wire

// File: hdl/msgpack_value_encoder_top.sv
// Top level of the MessagePack value encoder: input register, encoder, shifter.
// Depends on mpenc_pkg, mpenc_encode, mpenc_shifter and the assertion macros header.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | in_action .. in_payload_byte            | start & !busy accepts
//  result  | out_byte, out_last                      | out_valid marks each byte
//
// An item is registered on accept, encoded in the next cycle and loaded into the
// shifter once it is empty or on its last byte; the shifter sends one byte per cycle.
// The bytes of an item leave back to back; busy rises while the input register
// waits for the shifter to reach the last byte of the previous item.
// Single-byte items (payload bytes) stream at one per cycle if no longer frame drains.
// Reset (synchronous, active low) empties the input register and the shifter.
// The receiver cannot stall: every strobed byte is taken.
`default_nettype none

`include "msgpack_value_encoder_top_macros.svh"

module msgpack_value_encoder_top (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire        [3:0]  in_action,
  input  wire        [63:0] in_unsigned_value,
  input  wire signed [63:0] in_signed_value,
  input  wire        [31:0] in_length,
  input  wire signed [7:0]  in_ext_type,
  input  wire        [29:0] in_nanoseconds,
  input  wire               in_flag,
  input  wire        [7:0]  in_payload_byte,
  output logic              out_valid,
  output logic       [7:0]  out_byte,
  output logic              out_last
);

  mpenc_pkg::item_t      item_r;
  logic                  in_vld_r, in_vld_nxt;
  logic                  accept;
  logic                  load;
  mpenc_pkg::frame_t     frame;
  mpenc_pkg::sh_status_t sh_status;

  // shifter can take a frame when empty or on its final byte
  assign load   = in_vld_r && (!sh_status.valid || sh_status.last);
  assign busy   = in_vld_r && !load;
  assign accept = start && !busy;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (load) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.action         <= in_action;
      item_r.unsigned_value <= in_unsigned_value;
      item_r.signed_value   <= in_signed_value;
      item_r.length         <= in_length;
      item_r.ext_type       <= in_ext_type;
      item_r.nanoseconds    <= in_nanoseconds;
      item_r.flag           <= in_flag;
      item_r.payload_byte   <= in_payload_byte;
    end
  end

  mpenc_encode u_encode (
    .item  (item_r),
    .frame (frame)
  );

  mpenc_shifter u_shifter (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .frame    (frame),
    .status   (sh_status),
    .out_byte (out_byte)
  );

  assign out_valid = sh_status.valid;
  assign out_last  = sh_status.last;

  `MPENC_ASSERT_NEXT(a_accept_fills, start && !busy, in_vld_r, "accepted word not registered")
  `MPENC_ASSERT_NEXT(a_frame_whole, out_valid && !out_last, out_valid, "frame cut short")
  `MPENC_ASSERT_NOW(a_busy_drain, busy, out_valid && !out_last, "busy without draining frame")

endmodule

`default_nettype wire

// File: verif/tb_msgpack_value_encoder_top.sv
// Self-checking testbench for msgpack_value_encoder_top: drives value items and compares
// every output byte against a predicted MessagePack encoding. Depends on mpenc_pkg and the DUT.
`timescale 1ns / 1ps

module tb_msgpack_value_encoder_top;
  import mpenc_pkg::*;

  localparam logic [3:0] ACT_UNUSED_LO = 4'd12;

  localparam logic [63:0] INT_EDGES [21] = '{
    64'd0, 64'd31, 64'd32, 64'd33, 64'd127, 64'd128, 64'd129, 64'd255, 64'd256,
    64'd32767, 64'd32768, 64'd32769, 64'd65535, 64'd65536,
    64'h7FFF_FFFF, 64'h8000_0000, 64'h8000_0001, 64'hFFFF_FFFF, 64'h1_0000_0000,
    64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000
  };
  localparam logic [31:0] LEN_EDGES [17] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd12, 32'd15, 32'd16, 32'd17,
    32'd31, 32'd32, 32'd255, 32'd256, 32'd65535, 32'd65536, 32'hFFFF_FFFF
  };
  localparam logic [63:0] SEC_EDGES [8] = '{
    64'd0, 64'hFFFF_FFFF, 64'h1_0000_0000, 64'h3_FFFF_FFFF, 64'h4_0000_0000,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF
  };
  // biased exponents around the float32 normal and subnormal range
  localparam logic [10:0] EXP_EDGES [5] = '{
    11'd873, 11'd874, 11'd897, 11'd1150, 11'd1151
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  class encoded_byte_scoreboard;
    enc_byte_t  expected_bytes[$];
    logic [7:0] frame[$];
    int         errors;

    function void emit(logic [7:0] b);
      frame.push_back(b);
    endfunction

    function void emit_be(logic [63:0] v, int n);
      for (int k = n; k > 0; k--) emit(v[8*(k-1) +: 8]);
    endfunction

    function void encode_uint(logic [63:0] u);
      if (u <= 64'h7F) begin
        emit(u[7:0]);
      end else if (u <= 64'hFF) begin
        emit(MP_UINT8); emit(u[7:0]);
      end else if (u <= 64'hFFFF) begin
        emit(MP_UINT16); emit_be(u, 2);
      end else if (u <= 64'hFFFF_FFFF) begin
        emit(MP_UINT32); emit_be(u, 4);
      end else begin
        emit(MP_UINT64); emit_be(u, 8);
      end
    endfunction

    function void encode_int(logic [63:0] v);
      if (!v[63]) begin
        encode_uint(v);
      end else if (v >= 64'hFFFF_FFFF_FFFF_FFE0) begin
        emit(v[7:0]);
      end else if (v >= 64'hFFFF_FFFF_FFFF_FF80) begin
        emit(MP_INT8); emit(v[7:0]);
      end else if (v >= 64'hFFFF_FFFF_FFFF_8000) begin
        emit(MP_INT16); emit_be(v, 2);
      end else if (v >= 64'hFFFF_FFFF_8000_0000) begin
        emit(MP_INT32); emit_be(v, 4);
      end else begin
        emit(MP_INT64); emit_be(v, 8);
      end
    endfunction

    // 1 when the double is exactly representable as float32
    function bit single_exact(logic [63:0] d, output logic [31:0] f32);
      logic [10:0] ef;
      logic [51:0] frac;
      logic [52:0] m;
      logic [52:0] mask;
      int          e;
      int          s;
      ef   = d[62:52];
      frac = d[51:0];
      e    = int'(ef) - 1023;
      f32  = '0;
      if (ef == 11'h7FF) begin
        f32 = {d[63], 8'hFF, 23'd0};
        return frac == 0;
      end
      if (ef == 0) begin
        f32 = {d[63], 31'd0};
        return frac == 0;
      end
      if (e >= -126 && e <= 127) begin
        f32 = {d[63], 8'(e + 127), frac[51:29]};
        return frac[28:0] == 0;
      end
      if (e >= -149 && e <= -127) begin
        // lands in float32 subnormal range
        s    = -(e + 97);
        m    = {1'b1, frac};
        mask = (53'd1 << s) - 53'd1;
        f32  = {d[63], 31'(m >> s)};
        return (m & mask) == 0;
      end
      return 0;
    endfunction

    function void encode_float(logic [63:0] d);
      logic [31:0] f32;
      if (single_exact(d, f32)) begin
        emit(MP_FLOAT32); emit_be({32'd0, f32}, 4);
      end else begin
        emit(MP_FLOAT64); emit_be(d, 8);
      end
    endfunction

    function void encode_length(logic [31:0] len, bit has_fix, logic [7:0] fix_base,
                                logic [31:0] fix_max, bit has8, logic [7:0] c8,
                                logic [7:0] c16, logic [7:0] c32);
      if (has_fix && len <= fix_max) begin
        emit(fix_base | len[7:0]);
      end else if (has8 && len <= 32'hFF) begin
        emit(c8); emit(len[7:0]);
      end else if (len <= 32'hFFFF) begin
        emit(c16); emit_be({32'd0, len}, 2);
      end else begin
        emit(c32); emit_be({32'd0, len}, 4);
      end
    endfunction

    function void encode_ext(logic [31:0] len, logic [7:0] etype);
      case (len)
        32'd1:   emit(MP_FIXEXT1);
        32'd2:   emit(MP_FIXEXT2);
        32'd4:   emit(MP_FIXEXT4);
        32'd8:   emit(MP_FIXEXT8);
        32'd16:  emit(MP_FIXEXT16);
        default: encode_length(len, 0, 8'h00, 0, 1, MP_EXT8, MP_EXT16, MP_EXT32);
      endcase
      emit(etype);
    endfunction

    function void encode_timestamp(logic [63:0] sec, logic [29:0] ns);
      if (sec[63:34] == 0) begin
        if (ns == 0 && sec[33:32] == 0) begin
          emit(MP_FIXEXT4); emit(MP_TS_TYPE); emit_be(sec, 4);
        end else begin
          emit(MP_FIXEXT8); emit(MP_TS_TYPE); emit_be({ns, sec[33:0]}, 8);
        end
      end else begin
        emit(MP_EXT8); emit(MP_TS96_LEN); emit(MP_TS_TYPE);
        emit_be({34'd0, ns}, 4);
        emit_be(sec, 8);
      end
    endfunction

    function void note_item(item_t it);
      enc_byte_t eb;
      frame.delete();
      case (it.action)
        ACT_NIL:     emit(MP_NIL);
        ACT_BOOL:    emit(it.flag ? MP_TRUE : MP_FALSE);
        ACT_UINT:    encode_uint(it.unsigned_value);
        ACT_INT:     encode_int(it.signed_value);
        ACT_FLOAT:   encode_float(it.unsigned_value);
        ACT_STR:     encode_length(it.length, 1, MP_FIXSTR, 31, 1, MP_STR8, MP_STR16, MP_STR32);
        ACT_BIN:     encode_length(it.length, 0, 8'h00, 0, 1, MP_BIN8, MP_BIN16, MP_BIN32);
        ACT_ARRAY:   encode_length(it.length, 1, MP_FIXARRAY, 15, 0, 8'h00,
                                   MP_ARRAY16, MP_ARRAY32);
        ACT_MAP:     encode_length(it.length, 1, MP_FIXMAP, 15, 0, 8'h00, MP_MAP16, MP_MAP32);
        ACT_EXT:     encode_ext(it.length, it.ext_type);
        ACT_TSTAMP:  encode_timestamp(it.signed_value, it.nanoseconds);
        ACT_PAYLOAD: emit(it.payload_byte);
        default:     ; // unused codes produce nothing
      endcase
      foreach (frame[i]) begin
        eb.data = frame[i];
        eb.last = (i == frame.size() - 1);
        expected_bytes.push_back(eb);
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      enc_byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output word: out_byte=%02h out_last=%0b", data, last);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        $error("out_byte mismatch: expected %02h, actual %02h", want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $error("out_last mismatch: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic       clk   = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  item_t      drv   = '0;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  bit         quiet = 1'b0;

  encoded_byte_scoreboard enc_sb = new();

  msgpack_value_encoder_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (drv.action),
    .in_unsigned_value (drv.unsigned_value),
    .in_signed_value   (drv.signed_value),
    .in_length         (drv.length),
    .in_ext_type       (drv.ext_type),
    .in_nanoseconds    (drv.nanoseconds),
    .in_flag           (drv.flag),
    .in_payload_byte   (drv.payload_byte),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && busy === 1'b0) enc_sb.note_item(drv);
      if (out_valid) enc_sb.check_byte(out_byte, out_last);
    end
  end

  function automatic item_t random_fields();
    item_t f;
    f.action         = 4'($urandom);
    f.unsigned_value = {$urandom, $urandom};
    f.signed_value   = {$urandom, $urandom};
    f.length         = $urandom;
    f.ext_type       = 8'($urandom);
    f.nanoseconds    = 30'($urandom);
    f.flag           = 1'($urandom);
    f.payload_byte   = 8'($urandom);
    return f;
  endfunction

  function automatic logic [63:0] rand_integer();
    logic [63:0] v;
    case ($urandom_range(0, 3))
      0:       v = INT_EDGES[$urandom_range(0, 20)];
      1:       v = {$urandom, $urandom} >> $urandom_range(0, 63);
      2:       v = 64'($urandom_range(0, 300));
      default: v = {$urandom, $urandom};
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic logic [63:0] rand_double();
    logic [63:0] d;
    int          k;
    d = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: begin
        d[62:52] = 11'($urandom_range(1023 - 126, 1023 + 127));
        if ($urandom_range(0, 3) != 0) d[28:0] = '0;
      end
      2: begin
        k = $urandom_range(127, 149);
        d[62:52] = 11'(1023 - k);
        if ($urandom_range(0, 3) != 0) d[51:0] = d[51:0] & ~((52'd1 << (k - 97)) - 52'd1);
      end
      3: begin
        // infinity or NaN
        d[62:52] = '1;
        if ($urandom_range(0, 1)) d[51:0] = '0;
      end
      4: begin
        // zero or double subnormal
        d[62:52] = '0;
        if ($urandom_range(0, 2) == 0) d[51:0] = '0;
      end
      default: begin
        d[62:52] = EXP_EDGES[$urandom_range(0, 4)];
        if ($urandom_range(0, 1)) d[28:0] = '0;
      end
    endcase
    return d;
  endfunction

  function automatic logic [31:0] rand_length();
    case ($urandom_range(0, 3))
      0:       return LEN_EDGES[$urandom_range(0, 16)];
      1:       return $urandom_range(0, 40);
      2:       return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_seconds();
    case ($urandom_range(0, 3))
      0:       return {32'd0, $urandom};
      1:       return {30'd0, 2'($urandom), $urandom};
      2:       return SEC_EDGES[$urandom_range(0, 7)];
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [29:0] rand_nanos();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return 30'($urandom_range(0, 999999999));
      default: return 30'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] operand_for(logic [3:0] act);
    case (act)
      ACT_UINT, ACT_INT:                           return rand_integer();
      ACT_FLOAT:                                   return rand_double();
      ACT_STR, ACT_BIN, ACT_ARRAY, ACT_MAP, ACT_EXT: return {32'd0, rand_length()};
      ACT_TSTAMP:                                  return rand_seconds();
      default:                                     return {$urandom, $urandom};
    endcase
  endfunction

  task automatic pause_input(int n);
    @(negedge clk);
    start = 1'b0;
    drv   = random_fields();
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_item(item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 4));
    @(negedge clk);
    drv   = it;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // v carries the field the action uses; w carries ext type or nanoseconds
  task automatic send_op(logic [3:0] act, logic [63:0] v, logic [31:0] w);
    item_t it;
    it        = random_fields();
    it.action = act;
    case (act)
      ACT_BOOL:                            it.flag = v[0];
      ACT_UINT, ACT_FLOAT:                 it.unsigned_value = v;
      ACT_INT:                             it.signed_value = v;
      ACT_STR, ACT_BIN, ACT_ARRAY, ACT_MAP: it.length = v[31:0];
      ACT_PAYLOAD:                         it.payload_byte = v[7:0];
      ACT_EXT: begin
        it.length   = v[31:0];
        it.ext_type = w[7:0];
      end
      ACT_TSTAMP: begin
        it.signed_value = v;
        it.nanoseconds  = w[29:0];
      end
      default: ;
    endcase
    send_item(it);
  endtask

  initial begin
    int         sent;
    int         roll;
    int         seq_len;
    logic [3:0] act;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    quiet = 1'b1;
    send_op(ACT_NIL, 0, 0);
    send_op(ACT_BOOL, 0, 0);
    send_op(ACT_BOOL, 1, 0);
    send_op(ACT_UINT, 64'h7F, 0);
    send_op(ACT_UINT, 64'h80, 0);
    send_op(ACT_UINT, 64'h1_0000, 0);
    send_op(ACT_UINT, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_op(ACT_INT, -64'sd32, 0);
    send_op(ACT_INT, -64'sd33, 0);
    send_op(ACT_INT, 64'h8000_0000_0000_0000, 0);
    send_op(ACT_FLOAT, 64'h3FF0_0000_0000_0000, 0);   // 1.0
    send_op(ACT_FLOAT, 64'h7FF8_0000_0000_0001, 0);   // NaN
    send_op(ACT_FLOAT, 64'hFFF0_0000_0000_0000, 0);   // -inf
    send_op(ACT_FLOAT, 64'h36A0_0000_0000_0000, 0);   // smallest float32 subnormal
    send_op(ACT_FLOAT, 64'h0000_0000_0000_0001, 0);   // double subnormal
    send_op(ACT_STR, 31, 0);
    send_op(ACT_STR, 32, 0);
    send_op(ACT_BIN, 0, 0);
    send_op(ACT_ARRAY, 64'hFFFF_FFFF, 0);
    send_op(ACT_MAP, 16, 0);
    send_op(ACT_EXT, 0, 32'h80);
    send_op(ACT_EXT, 16, 32'h7F);
    send_op(ACT_TSTAMP, 64'hFFFF_FFFF, 0);
    send_op(ACT_TSTAMP, 64'h3_FFFF_FFFF, 32'h3FFF_FFFF);
    send_op(ACT_TSTAMP, 64'hFFFF_FFFF_FFFF_FFFF, 999999999);
    send_op(ACT_PAYLOAD, 64'hFF, 0);
    send_op(ACT_UNUSED_LO + 4'd3, 0, 0);

    sent = 0;
    while (sent < 420) begin
      quiet = (sent >= 360);
      roll  = $urandom_range(0, 99);
      if (roll < 15) begin
        // header followed by its data bytes
        case ($urandom_range(0, 2))
          0:       act = ACT_STR;
          1:       act = ACT_BIN;
          default: act = ACT_EXT;
        endcase
        seq_len = $urandom_range(0, 8);
        send_op(act, seq_len, $urandom);
        repeat (seq_len) send_op(ACT_PAYLOAD, {$urandom, $urandom}, 0);
        sent += seq_len + 1;
      end else if (roll < 18) begin
        send_op(ACT_UNUSED_LO + 4'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom);
      end else begin
        act = 4'($urandom_range(ACT_NIL, ACT_PAYLOAD));
        send_op(act, operand_for(act), act == ACT_TSTAMP ? 32'(rand_nanos()) : $urandom);
        sent++;
      end
    end

    @(negedge clk) start = 1'b0;
    while (enc_sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (enc_sb.errors == 0) begin
      $display("PASS msgpack_value_encoder_top");
    end else begin
      $display("FAIL msgpack_value_encoder_top");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL msgpack_value_encoder_top");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/mpenc_pkg.sv
hdl/mpenc_encode.sv
hdl/mpenc_shifter.sv
hdl/msgpack_value_encoder_top.sv
verif/tb_msgpack_value_encoder_top.sv
